FILE: design/vfv_pkg.sv
// Package for the voxel face visibility unit: grid geometry, coordinate and
// address widths, the grid memory request struct and the cell address function.
// No dependencies.
package vfv_pkg;

	localparam int SIZE_X = 16;
	localparam int SIZE_Y = 16;
	localparam int SIZE_Z = 16;

	localparam int PLANE_CELLS = SIZE_X * SIZE_Y;
	localparam int GRID_CELLS  = PLANE_CELLS * SIZE_Z;

	localparam int XW     = (SIZE_X > 1) ? $clog2(SIZE_X) : 1;
	localparam int YW     = (SIZE_Y > 1) ? $clog2(SIZE_Y) : 1;
	localparam int ZW     = (SIZE_Z > 1) ? $clog2(SIZE_Z) : 1;
	localparam int ADDR_W = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;

	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(GRID_CELLS - 1);

	localparam int CELL_W = 8;
	localparam int MASK_W = 6;
	localparam int CNT_W  = 3;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic              en;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [CELL_W-1:0] wdata;
	} grid_req_t;

	// linear index z*SIZE_X*SIZE_Y + y*SIZE_X + x
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [XW-1:0] x,
		input logic [YW-1:0] y, input logic [ZW-1:0] z);
		int lin;
		lin = int'(z) * PLANE_CELLS + int'(y) * SIZE_X + int'(x);
		return ADDR_W'(lin);
	endfunction

endpackage

FILE: design/vfv_req_if.sv
// Input channel of the voxel face visibility unit: valid/ready plus one item.
// No dependencies.
interface vfv_req_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] coord_x;
	logic [7:0] coord_y;
	logic [7:0] coord_z;
	logic [7:0] cell_value;

	modport source (output valid, opcode, coord_x, coord_y, coord_z, cell_value,
		input ready);
	modport sink (input valid, opcode, coord_x, coord_y, coord_z, cell_value,
		output ready);
endinterface

FILE: design/vfv_rsp_if.sv
// Result channel of the voxel face visibility unit: valid/ready plus one result.
// No dependencies.
interface vfv_rsp_if;
	logic       valid;
	logic       ready;
	logic       accepted;
	logic [7:0] cell_kind;
	logic [5:0] face_mask;
	logic [2:0] face_count;
	logic       on_surface;

	modport source (output valid, accepted, cell_kind, face_mask, face_count,
		on_surface, input ready);
	modport sink (input valid, accepted, cell_kind, face_mask, face_count,
		on_surface, output ready);
endinterface

FILE: design/vfv_grid.sv
// Voxel grid memory: single port, synchronous read with registered data, and
// the clearing pass that zeroes every cell after reset. Uses vfv_pkg.
module vfv_grid
	import vfv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  grid_req_t         req,
	output logic              busy,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [GRID_CELLS];
	logic [CELL_W-1:0] rdata_q;
	logic [ADDR_W-1:0] clr_q;
	logic              busy_q;

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= '0;
		end else if (req.en) begin
			if (req.we) begin
				mem[req.addr] <= req.wdata;
			end else begin
				rdata_q <= mem[req.addr];
			end
		end
	end

	// sweep one cell per cycle until the last one is cleared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			if (clr_q == LAST_CELL) begin
				busy_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	assign busy  = busy_q;
	assign rdata = rdata_q;

endmodule

FILE: design/voxel_face_visibility_unit.sv
// Voxel face visibility unit, top level: item sequencer, result register and
// APB register port. Uses vfv_pkg, vfv_req_if, vfv_rsp_if and vfv_grid.
module voxel_face_visibility_unit
	import vfv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	vfv_req_if.sink     req,
	vfv_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// After reset the grid memory is swept to zero, one cell a cycle; no item is
	// taken during the sweep, register writes are. Items are handled one at a time
	// through the single grid memory port. A query issues seven reads, the voxel
	// and its six neighbours, one per cycle, then passes through a last state and a
	// done state; a write passes through the write and done states. The done state
	// holds while the output register is full and not taken. A result waits in its
	// output register while the next item is taken.

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_WRITE = 5'b00010,
		ST_READ  = 5'b00100,
		ST_LAST  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	localparam logic [2:0] STEP_C  = 3'd0;
	localparam logic [2:0] STEP_PX = 3'd1;
	localparam logic [2:0] STEP_PY = 3'd2;
	localparam logic [2:0] STEP_PZ = 3'd3;
	localparam logic [2:0] STEP_NX = 3'd4;
	localparam logic [2:0] STEP_NY = 3'd5;
	localparam logic [2:0] STEP_NZ = 3'd6;

	state_t             state_q;
	logic [2:0]         step_q;
	logic               op_q;
	logic [7:0]         x_q, y_q, z_q;
	logic [CELL_W-1:0]  val_q;
	logic               acc_q;
	logic [CELL_W-1:0]  kind_q;
	logic [MASK_W-1:0]  mask_q;
	logic [7:0]         type_count_q;

	logic               rd_en_s1;
	logic               rd_ok_s1;
	logic [2:0]         rd_step_s1;

	logic               rsp_valid_q;
	logic               rsp_acc_q;
	logic [CELL_W-1:0]  rsp_kind_q;
	logic [MASK_W-1:0]  rsp_mask_q;
	logic [CNT_W-1:0]   rsp_count_q;
	logic               rsp_surf_q;

	logic [8:0]         nx, ny, nz;
	logic               n_ok;
	logic [ADDR_W-1:0]  n_addr;
	logic               wr_ok;
	logic               in_xfer;
	logic               out_free;
	logic               load_rsp;
	logic               cfg_wr;
	logic [MASK_W-1:0]  fin_mask;
	logic [2:0]         bit_idx;
	grid_req_t          grid_req;
	logic               grid_busy;
	logic [CELL_W-1:0]  grid_rdata;

	vfv_grid u_grid (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (grid_req),
		.busy   (grid_busy),
		.rdata  (grid_rdata)
	);

	// coordinates of the cell read at the current step
	always_comb begin
		nx = {1'b0, x_q};
		ny = {1'b0, y_q};
		nz = {1'b0, z_q};
		case (step_q)
			STEP_C:  ;
			STEP_PX: nx = {1'b0, x_q} + 9'd1;
			STEP_PY: ny = {1'b0, y_q} + 9'd1;
			STEP_PZ: nz = {1'b0, z_q} + 9'd1;
			STEP_NX: nx = {1'b0, x_q} - 9'd1;
			STEP_NY: ny = {1'b0, y_q} - 9'd1;
			STEP_NZ: nz = {1'b0, z_q} - 9'd1;
			default: ;
		endcase
		n_ok   = (nx < 9'(SIZE_X)) && (ny < 9'(SIZE_Y)) && (nz < 9'(SIZE_Z));
		n_addr = n_ok ? cell_addr(nx[XW-1:0], ny[YW-1:0], nz[ZW-1:0]) : '0;
	end

	assign wr_ok = n_ok && (val_q <= type_count_q);

	always_comb begin
		grid_req.en    = (state_q == ST_READ) || ((state_q == ST_WRITE) && wr_ok);
		grid_req.we    = (state_q == ST_WRITE);
		grid_req.addr  = n_addr;
		grid_req.wdata = val_q;
	end

	assign req.ready = (state_q == ST_IDLE) && !grid_busy;
	assign in_xfer   = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign load_rsp  = (state_q == ST_DONE) && out_free;
	assign bit_idx   = rd_step_s1 - 3'd1;
	assign fin_mask  = (kind_q != '0) ? mask_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= STEP_C;
			rd_en_s1 <= 1'b0;
		end else begin
			rd_en_s1 <= (state_q == ST_READ);
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						step_q  <= STEP_C;
						state_q <= (req.opcode == OP_WRITE) ? ST_WRITE : ST_READ;
					end
				end
				ST_WRITE: state_q <= ST_DONE;
				ST_READ: begin
					if (step_q == STEP_NZ) begin
						state_q <= ST_LAST;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_LAST: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item payload and the result being gathered
	always_ff @(posedge clk) begin
		rd_ok_s1   <= n_ok;
		rd_step_s1 <= step_q;
		if (in_xfer) begin
			op_q   <= req.opcode;
			x_q    <= req.coord_x;
			y_q    <= req.coord_y;
			z_q    <= req.coord_z;
			val_q  <= req.cell_value;
			acc_q  <= 1'b0;
			kind_q <= '0;
			mask_q <= '0;
		end else if (state_q == ST_WRITE) begin
			acc_q <= wr_ok;
		end else if (rd_en_s1) begin
			if (rd_step_s1 == STEP_C) begin
				acc_q  <= rd_ok_s1;
				kind_q <= rd_ok_s1 ? grid_rdata : '0;
			end else begin
				mask_q[bit_idx] <= !rd_ok_s1 || (grid_rdata == '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_acc_q   <= acc_q;
			rsp_kind_q  <= (op_q == OP_QUERY) ? kind_q : '0;
			rsp_mask_q  <= (op_q == OP_QUERY) ? fin_mask : '0;
			rsp_count_q <= (op_q == OP_QUERY) ? CNT_W'($countones(fin_mask)) : '0;
			rsp_surf_q  <= (op_q == OP_QUERY) && (fin_mask != '0);
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.accepted   = rsp_acc_q;
	assign rsp.cell_kind  = rsp_kind_q;
	assign rsp.face_mask  = rsp_mask_q;
	assign rsp.face_count = rsp_count_q;
	assign rsp.on_surface = rsp_surf_q;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_count_q <= 8'd255;
		end else if (cfg_wr) begin
			type_count_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == 1'b0) ? {24'd0, type_count_q} : 32'd0;

`ifndef ASSERT_OFF
	a_no_access_during_clear: assert property (@(posedge clk) disable iff (!arst_n)
		grid_req.en |-> !grid_busy)
		else $error("grid accessed during clearing pass");

	a_read_follows_issue: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en_s1 |-> $past(state_q == ST_READ))
		else $error("read data consumed without a read issued");

	a_empty_has_no_faces: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (rsp_kind_q == '0) |-> (rsp_mask_q == '0) && !rsp_surf_q)
		else $error("empty voxel reported with exposed faces");

	a_done_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && !rsp_valid_q |=> rsp_valid_q)
		else $error("finished item did not reach the result register");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result shown without a finished item");
`endif

endmodule
